// ----- rtl/core/scc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;

	localparam int NODE_W = 7;
	localparam int COMP_W = 6;
	localparam int NIDX_W = $clog2(MAX_NODES);
	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int ECNT_W = $clog2(MAX_EDGES + 1);

	// request commands
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT_F,
		OP_OUTER_F,
		OP_SCAN_RD,
		OP_SCAN_EV,
		OP_FINISH,
		OP_POP,
		OP_INIT_R,
		OP_OUTER_R,
		OP_OUTER_R2
	} ctl_op_t;

	typedef struct packed {
		logic    accept;
		ctl_op_t op;
		logic    rev;
	} ctl_cmd_t;

	typedef struct packed {
		logic s_over;
		logic s_visited;
		logic scan_end;
		logic sp_zero;
		logic i_zero;
		logic start_ok;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/scc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         cmd,
	input  wire scc_pkg::dp_status_t status,
	output scc_pkg::ctl_cmd_t       ctl,
	output logic                    busy
);
	import scc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_F,
		ST_OUTER_F,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_FINISH,
		ST_POP,
		ST_INIT_R,
		ST_OUTER_R,
		ST_OUTER_R2
	} state_t;

	state_t state_q;
	logic   rev_q;
	logic   accept;

	assign accept = start && !busy;

	always_comb begin
		ctl.accept = accept;
		ctl.rev    = rev_q;
		case (state_q)
			ST_INIT_F:   ctl.op = OP_INIT_F;
			ST_OUTER_F:  ctl.op = OP_OUTER_F;
			ST_SCAN_RD:  ctl.op = OP_SCAN_RD;
			ST_SCAN_EV:  ctl.op = OP_SCAN_EV;
			ST_FINISH:   ctl.op = OP_FINISH;
			ST_POP:      ctl.op = OP_POP;
			ST_INIT_R:   ctl.op = OP_INIT_R;
			ST_OUTER_R:  ctl.op = OP_OUTER_R;
			ST_OUTER_R2: ctl.op = OP_OUTER_R2;
			default:     ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rev_q   <= 1'b0;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_RUN) begin
						state_q <= ST_INIT_F;
						rev_q   <= 1'b0;
						busy    <= 1'b1;
					end
				end
				ST_INIT_F: state_q <= ST_OUTER_F;
				ST_OUTER_F: begin
					if (status.s_over)
						state_q <= ST_INIT_R;
					else if (!status.s_visited)
						state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: state_q <= status.scan_end ? ST_FINISH : ST_SCAN_EV;
				ST_SCAN_EV: state_q <= ST_SCAN_RD;
				ST_FINISH: begin
					if (!status.sp_zero)
						state_q <= ST_POP;
					else
						state_q <= rev_q ? ST_OUTER_R : ST_OUTER_F;
				end
				ST_POP: state_q <= ST_SCAN_RD;
				ST_INIT_R: begin
					state_q <= ST_OUTER_R;
					rev_q   <= 1'b1;
				end
				ST_OUTER_R: begin
					if (status.i_zero) begin
						state_q <= ST_IDLE;
						busy    <= 1'b0;
					end else begin
						state_q <= ST_OUTER_R2;
					end
				end
				ST_OUTER_R2: state_q <= status.start_ok ? ST_SCAN_RD : ST_OUTER_R;
				default: begin
					state_q <= ST_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/scc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scc_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire scc_pkg::ctl_cmd_t            ctl,
	input  wire logic [1:0]                   cmd,
	input  wire logic [scc_pkg::NODE_W-1:0]   src_node,
	input  wire logic [scc_pkg::NODE_W-1:0]   dst_node,
	input  wire logic                         node_count_we,
	input  wire logic [scc_pkg::NODE_W-1:0]   node_count_wdata,
	output scc_pkg::dp_status_t               status,
	output logic                              result_valid,
	output logic [scc_pkg::NODE_W-1:0]        node,
	output logic [scc_pkg::COMP_W-1:0]        component,
	output logic                              last_in_component,
	output logic                              last_of_run,
	output logic                              edges_dropped
);
	import scc_pkg::*;

	// storage
	logic [NODE_W-1:0] edge_src_mem [MAX_EDGES];
	logic [NODE_W-1:0] edge_dst_mem [MAX_EDGES];
	logic [NODE_W-1:0] finish_mem [MAX_NODES];
	logic [NODE_W-1:0] stk_node_mem [MAX_NODES];
	logic [ECNT_W-1:0] stk_scan_mem [MAX_NODES];

	logic [NODE_W-1:0] node_count_q;
	logic [ECNT_W-1:0] edge_total_q;
	logic              drop_q;
	logic [MAX_NODES-1:0] visited_q;

	logic [NODE_W-1:0] s_q, fc_q, i_q, sp_q, cur_q;
	logic [ECNT_W-1:0] scan_q;
	logic [COMP_W-1:0] comp_q;

	logic [NODE_W-1:0] esrc_q, edst_q, fin_rd_q, stk_node_rd_q;
	logic [ECNT_W-1:0] stk_scan_rd_q;

	// pending result, flushed when its flags are known
	logic              pend_v_q, pend_lic_q;
	logic [NODE_W-1:0] pend_node_q;
	logic [COMP_W-1:0] pend_comp_q;

	logic [NODE_W-1:0] n_eff;
	logic [NODE_W-1:0] from_n, to_n;
	logic              hit, add_ok, st_ok;

	always_comb begin
		if (node_count_q == '0)
			n_eff = NODE_W'(1);
		else if (node_count_q > NODE_W'(MAX_NODES))
			n_eff = NODE_W'(MAX_NODES);
		else
			n_eff = node_count_q;
	end

	assign from_n = ctl.rev ? edst_q : esrc_q;
	assign to_n   = ctl.rev ? esrc_q : edst_q;
	assign hit = esrc_q != '0 && esrc_q <= n_eff && edst_q != '0 && edst_q <= n_eff
		&& from_n == cur_q && !visited_q[NIDX_W'(to_n - NODE_W'(1))];
	assign add_ok = src_node != '0 && src_node <= n_eff && dst_node != '0
		&& dst_node <= n_eff && edge_total_q < ECNT_W'(MAX_EDGES);
	assign st_ok = fin_rd_q != '0 && fin_rd_q <= n_eff
		&& !visited_q[NIDX_W'(fin_rd_q - NODE_W'(1))];

	always_comb begin
		status.s_over    = s_q > n_eff;
		status.s_visited = visited_q[NIDX_W'(s_q - NODE_W'(1))];
		status.scan_end  = scan_q >= edge_total_q;
		status.sp_zero   = sp_q == '0;
		status.i_zero    = i_q == '0;
		status.start_ok  = st_ok;
	end

	// memories
	always_ff @(posedge clk) begin
		if (ctl.accept && cmd == CMD_ADD && add_ok) begin
			edge_src_mem[edge_total_q[EIDX_W-1:0]] <= src_node;
			edge_dst_mem[edge_total_q[EIDX_W-1:0]] <= dst_node;
		end
		esrc_q <= edge_src_mem[scan_q[EIDX_W-1:0]];
		edst_q <= edge_dst_mem[scan_q[EIDX_W-1:0]];
		if (ctl.op == OP_FINISH && !ctl.rev && fc_q < NODE_W'(MAX_NODES))
			finish_mem[fc_q[NIDX_W-1:0]] <= cur_q;
		fin_rd_q <= finish_mem[NIDX_W'(i_q - NODE_W'(1))];
		if (ctl.op == OP_SCAN_EV && hit) begin
			stk_node_mem[sp_q[NIDX_W-1:0]] <= cur_q;
			stk_scan_mem[sp_q[NIDX_W-1:0]] <= scan_q + ECNT_W'(1);
		end
		stk_node_rd_q <= stk_node_mem[NIDX_W'(sp_q - NODE_W'(1))];
		stk_scan_rd_q <= stk_scan_mem[NIDX_W'(sp_q - NODE_W'(1))];
	end

	// configuration and edge store control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_W'(1);
			edge_total_q <= '0;
			drop_q       <= 1'b0;
		end else begin
			if (node_count_we)
				node_count_q <= node_count_wdata;
			if (ctl.accept && cmd == CMD_CLEAR) begin
				edge_total_q <= '0;
				drop_q       <= 1'b0;
			end else if (ctl.accept && cmd == CMD_ADD) begin
				if (add_ok)
					edge_total_q <= edge_total_q + ECNT_W'(1);
				else
					drop_q <= 1'b1;
			end
		end
	end

	// search walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q    <= '0;
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
			s_q    <= '0;
			fc_q   <= '0;
			i_q    <= '0;
			sp_q   <= '0;
			cur_q  <= '0;
			scan_q <= '0;
			comp_q <= '0;
		end else begin
			result_valid <= 1'b0;
			case (ctl.op)
				OP_INIT_F, OP_INIT_R: begin
					visited_q <= '0;
					if (ctl.op == OP_INIT_F) begin
						s_q      <= NODE_W'(1);
						fc_q     <= '0;
						comp_q   <= '0;
						pend_v_q <= 1'b0;
					end else begin
						i_q <= fc_q;
					end
				end
				OP_OUTER_F: begin
					if (!status.s_over) begin
						if (status.s_visited) begin
							s_q <= s_q + NODE_W'(1);
						end else begin
							visited_q[NIDX_W'(s_q - NODE_W'(1))] <= 1'b1;
							cur_q  <= s_q;
							scan_q <= '0;
							sp_q   <= '0;
						end
					end
				end
				OP_SCAN_EV: begin
					if (hit) begin
						visited_q[NIDX_W'(to_n - NODE_W'(1))] <= 1'b1;
						sp_q   <= sp_q + NODE_W'(1);
						cur_q  <= to_n;
						scan_q <= '0;
						if (ctl.rev) begin
							result_valid      <= pend_v_q;
							node              <= pend_node_q;
							component         <= pend_comp_q;
							last_in_component <= pend_lic_q;
							last_of_run       <= 1'b0;
							edges_dropped     <= drop_q;
							pend_v_q    <= 1'b1;
							pend_node_q <= to_n;
							pend_comp_q <= comp_q;
							pend_lic_q  <= 1'b0;
						end
					end else begin
						scan_q <= scan_q + ECNT_W'(1);
					end
				end
				OP_FINISH: begin
					if (!ctl.rev && fc_q < NODE_W'(MAX_NODES))
						fc_q <= fc_q + NODE_W'(1);
					if (!status.sp_zero) begin
						sp_q <= sp_q - NODE_W'(1);
					end else if (ctl.rev) begin
						pend_lic_q <= 1'b1;
						comp_q     <= comp_q + COMP_W'(1);
					end else begin
						s_q <= s_q + NODE_W'(1);
					end
				end
				OP_POP: begin
					cur_q  <= stk_node_rd_q;
					scan_q <= stk_scan_rd_q;
				end
				OP_OUTER_R: begin
					if (!status.i_zero) begin
						i_q <= i_q - NODE_W'(1);
					end else begin
						// end of run: flush the held result as final
						result_valid      <= pend_v_q;
						node              <= pend_node_q;
						component         <= pend_comp_q;
						last_in_component <= pend_lic_q;
						last_of_run       <= 1'b1;
						edges_dropped     <= drop_q;
						pend_v_q          <= 1'b0;
					end
				end
				OP_OUTER_R2: begin
					if (st_ok) begin
						visited_q[NIDX_W'(fin_rd_q - NODE_W'(1))] <= 1'b1;
						cur_q  <= fin_rd_q;
						scan_q <= '0;
						sp_q   <= '0;
						result_valid      <= pend_v_q;
						node              <= pend_node_q;
						component         <= pend_comp_q;
						last_in_component <= pend_lic_q;
						last_of_run       <= 1'b0;
						edges_dropped     <= drop_q;
						pend_v_q    <= 1'b1;
						pend_node_q <= fin_rd_q;
						pend_comp_q <= comp_q;
						pend_lic_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/strongly_connected_components_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Strongly connected components (Kosaraju) over a loaded edge store.
// Request channel: cmd/src_node/dst_node taken on a clock edge with start
// high and busy low. Clear and add-edge requests give no result and never
// raise busy, so edges load one per cycle while busy is low.
// A run request raises busy for the whole search. Results appear on
// node/component/last_in_component/last_of_run/edges_dropped, one per
// node, each for exactly one cycle with result_valid high; the receiver
// cannot stall, so no backpressure exists.
// Search: each depth-first pass rescans the edge store from the start for
// every node it enters, each stored edge by a registered edge memory read,
// then a compare, plus steps for each push, pop and start node.
// The last result shows in the cycle busy drops.
// node_count: node_count_we/node_count_wdata, written by the user only while
// idle (not enforced by the block); 0 acts as 1, values above 64 act as 64.
// Reset (arst_n low): empty edge store, drop flag clear, node_count 1,
// controller idle. No clearing pass is needed.
module strongly_connected_components_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 cmd,
	input  wire logic [scc_pkg::NODE_W-1:0] src_node,
	input  wire logic [scc_pkg::NODE_W-1:0] dst_node,
	input  wire logic                       node_count_we,
	input  wire logic [scc_pkg::NODE_W-1:0] node_count_wdata,
	output logic                            result_valid,
	output logic [scc_pkg::NODE_W-1:0]      node,
	output logic [scc_pkg::COMP_W-1:0]      component,
	output logic                            last_in_component,
	output logic                            last_of_run,
	output logic                            edges_dropped
);
	import scc_pkg::*;

	ctl_cmd_t   ctl;
	dp_status_t status;

	// sequencer: walks both passes, one op per cycle
	scc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.status (status),
		.ctl    (ctl),
		.busy   (busy)
	);

	// edge store, stack, finish list, visited bits, result staging
	scc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.cmd               (cmd),
		.src_node          (src_node),
		.dst_node          (dst_node),
		.node_count_we     (node_count_we),
		.node_count_wdata  (node_count_wdata),
		.status            (status),
		.result_valid      (result_valid),
		.node              (node),
		.component         (component),
		.last_in_component (last_in_component),
		.last_of_run       (last_of_run),
		.edges_dropped     (edges_dropped)
	);
endmodule
`default_nettype wire
